// ===== hw/rtl/sdp_pkg.sv =====
// Shared types and constants for the signed decimal parser.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package sdp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned MagW   = 63;
  localparam int unsigned CountW = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [CharW-1:0] CharSuffixLong = 8'h6A;  // 'j'
  localparam logic [CharW-1:0] CharSuffixInt  = 8'h69;  // 'i'
  localparam logic [CharW-1:0] CharNull       = 8'h4E;  // 'N'
  localparam logic [CharW-1:0] CharInf        = 8'h57;  // 'W'
  localparam logic [CharW-1:0] CharMinus      = 8'h2D;  // '-'
  localparam logic [CharW-1:0] CharZero       = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharNine       = 8'h39;  // '9'

  localparam logic [MagW-1:0] MaxLong = {MagW{1'b1}};
  localparam logic [MagW-1:0] MaxInt  = {{(MagW-31){1'b0}}, {31{1'b1}}};

  localparam logic [AddrW-3:0] RegNarrowMode = '0;

  typedef enum logic [1:0] {
    KIND_ORDINARY = 2'd0,
    KIND_NULL     = 2'd1,
    KIND_POS_INF  = 2'd2,
    KIND_NEG_INF  = 2'd3
  } kind_e;

  typedef struct packed {
    logic narrow_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/sdp_if.sv =====
// Valid/ready channel interfaces for character beats and result beats.
// Depends on sdp_pkg for field widths and the kind type.
`timescale 1ns / 1ps

interface sdp_char_if;
  logic                     valid;
  logic                     ready;
  logic [sdp_pkg::CharW-1:0] ch;
  logic                     is_last;
  logic                     empty_token;

  modport source (output valid, ch, is_last, empty_token, input ready);
  modport sink   (input valid, ch, is_last, empty_token, output ready);
endinterface

interface sdp_res_if;
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic [sdp_pkg::ValueW-1:0] value;
  sdp_pkg::kind_e            kind;

  modport source (output valid, valid_res, value, kind, input ready);
  modport sink   (input valid, valid_res, value, kind, output ready);
endinterface

// ===== hw/rtl/sdp_cfg_regs.sv =====
// APB-style configuration register holding the width mode of the parser.
// Depends on sdp_pkg for address width, register index and the cfg_t struct.
`timescale 1ns / 1ps

module sdp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdp_pkg::AddrW-1:0]   paddr,
  input  logic [sdp_pkg::DataW-1:0]   pwdata,
  output logic [sdp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output sdp_pkg::cfg_t               cfg_o
);
  import sdp_pkg::*;

  logic narrow_q, narrow_d;
  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[AddrW-1:2] == RegNarrowMode);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_comb begin
    narrow_d = narrow_q;
    if (wr_en) begin
      narrow_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_q <= 1'b0;
    end else begin
      narrow_q <= narrow_d;
    end
  end

  assign prdata            = hit ? {{(DataW-1){1'b0}}, narrow_q} : '0;
  assign cfg_o.narrow_mode = narrow_q;

endmodule

// ===== hw/rtl/sdp_core.sv =====
// Character input register, token state update and result register.
// Depends on sdp_pkg and the channel interfaces in sdp_if.sv.
`timescale 1ns / 1ps

module sdp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sdp_pkg::cfg_t cfg_i,
  sdp_char_if.sink      char_i,
  sdp_res_if.source     res_o
);
  import sdp_pkg::*;

  localparam int unsigned WideW = MagW + 4;

  // Input register.
  logic             in_valid_q;
  logic [CharW-1:0] ch_q;
  logic             last_q;
  logic             empty_q;

  // Token state.
  logic              at_start_q, at_start_d;
  logic              neg_q, neg_d;
  logic              bad_q, bad_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              fz_q, fz_d;
  logic [CharW-1:0]  sc_q, sc_d;
  logic [MagW-1:0]   acc_q, acc_d;

  // Result register.
  logic              out_valid_q;
  logic              rv_q, rv_d;
  logic [ValueW-1:0] val_q, val_d;
  kind_e             kind_q, kind_d;

  logic             ends;
  logic             res_free;
  logic             s2_go;
  logic             accept;
  logic [CharW-1:0] suffix;
  logic [MagW-1:0]  maxv;
  logic             is_sign;
  logic             is_suffix;
  logic             is_digit;
  logic [WideW-1:0] acc10;
  logic             sc_digit;
  logic [ValueW-1:0] max_ext;
  logic [ValueW-1:0] acc_ext;

  assign ends     = last_q || empty_q;
  assign res_free = !out_valid_q || res_o.ready;
  assign s2_go    = in_valid_q && (!ends || res_free);
  assign char_i.ready = !in_valid_q || s2_go;
  assign accept   = char_i.valid && char_i.ready;

  assign suffix    = cfg_i.narrow_mode ? CharSuffixInt : CharSuffixLong;
  assign maxv      = cfg_i.narrow_mode ? MaxInt : MaxLong;
  assign is_sign   = at_start_q && (ch_q == CharMinus);
  assign is_suffix = !is_sign && last_q && (ch_q == suffix);
  assign is_digit  = ch_q inside {[CharZero:CharNine]};
  assign acc10     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                   + {{(WideW-4){1'b0}}, 4'(ch_q - CharZero)};
  assign max_ext   = {1'b0, maxv};

  always_comb begin
    at_start_d = at_start_q;
    neg_d      = neg_q;
    bad_d      = bad_q;
    ovf_d      = ovf_q;
    cnt_d      = cnt_q;
    fz_d       = fz_q;
    sc_d       = sc_q;
    acc_d      = acc_q;
    rv_d       = 1'b0;
    val_d      = '0;
    kind_d     = KIND_ORDINARY;
    sc_digit   = 1'b0;
    acc_ext    = '0;

    if (!empty_q) begin
      at_start_d = 1'b0;
      if (is_sign) begin
        neg_d = 1'b1;
      end else if (!is_suffix) begin
        if (cnt_q == CountW'(0)) begin
          fz_d = (ch_q == CharZero);
        end else if (cnt_q == CountW'(1)) begin
          sc_d = ch_q;
        end
        if (cnt_q != {CountW{1'b1}}) begin
          cnt_d = cnt_q + CountW'(1);
        end
        if (!is_digit) begin
          bad_d = 1'b1;
        end else if (!ovf_q) begin
          if (acc10 > {{(WideW-MagW){1'b0}}, maxv}) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = acc10[MagW-1:0];
          end
        end
      end

      sc_digit = sc_d inside {[CharZero:CharNine]};
      acc_ext  = {1'b0, acc_d};
      if ((cnt_d == CountW'(2)) && fz_d && !sc_digit) begin
        if (sc_d == CharNull) begin
          if (!neg_d) begin
            rv_d   = 1'b1;
            val_d  = ~max_ext;
            kind_d = KIND_NULL;
          end
        end else if (sc_d == CharInf) begin
          rv_d   = 1'b1;
          val_d  = neg_d ? (~max_ext + ValueW'(1)) : max_ext;
          kind_d = neg_d ? KIND_NEG_INF : KIND_POS_INF;
        end
      end else if (!bad_d && !ovf_d) begin
        rv_d  = 1'b1;
        val_d = neg_d ? (~acc_ext + ValueW'(1)) : acc_ext;
      end
    end

    if (ends) begin
      at_start_d = 1'b1;
      neg_d      = 1'b0;
      bad_d      = 1'b0;
      ovf_d      = 1'b0;
      cnt_d      = '0;
      fz_d       = 1'b0;
      sc_d       = '0;
      acc_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      at_start_q  <= 1'b1;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      fz_q        <= 1'b0;
      sc_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (char_i.ready) begin
        in_valid_q <= char_i.valid;
      end
      if (s2_go) begin
        at_start_q <= at_start_d;
        neg_q      <= neg_d;
        bad_q      <= bad_d;
        ovf_q      <= ovf_d;
        cnt_q      <= cnt_d;
        fz_q       <= fz_d;
        sc_q       <= sc_d;
        acc_q      <= acc_d;
      end
      if (s2_go && ends) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q    <= char_i.ch;
      last_q  <= char_i.is_last;
      empty_q <= char_i.empty_token;
    end
    if (s2_go && ends) begin
      rv_q   <= rv_d;
      val_q  <= val_d;
      kind_q <= kind_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.valid_res = rv_q;
  assign res_o.value     = val_q;
  assign res_o.kind      = kind_q;

  a_empty_gives_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && empty_q) |=> (out_valid_q && !rv_q && (kind_q == KIND_ORDINARY)))
    else $error("empty token mark did not yield an invalid result");

  a_token_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && ends) |=> (at_start_q && (acc_q == '0) && (cnt_q == '0)))
    else $error("token state not cleared after the last beat");

  a_special_kind_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q != KIND_ORDINARY)) |-> rv_q)
    else $error("special kind reported on an invalid result");

  a_count_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s2_go && ends) |=> (cnt_q >= $past(cnt_q)))
    else $error("body count fell inside a token");

endmodule

// ===== hw/rtl/signed_decimal_parser_unit.sv =====
// Top level of the signed decimal parser: configuration port and parser core.
// Depends on sdp_pkg, sdp_if.sv, sdp_cfg_regs and sdp_core.
//
//   channel   direction  beat contents
//   char_i    in         ch, is_last, empty_token
//   res_o     out        valid_res, value, kind
//   APB       in/out     narrow_mode at byte address 0
//
// One character beat is taken in every cycle while no token end waits for the
// result register; a result beat passes through the input register and then the
// result register, around the single multiply-by-ten, add and bound check.
// Reset clears the width mode to 64-bit and puts the parser at a token start.
// While a result beat waits, characters that do not end a token still flow;
// a token end waits for the result register to be free.
`timescale 1ns / 1ps

module signed_decimal_parser_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdp_pkg::AddrW-1:0] paddr,
  input  logic [sdp_pkg::DataW-1:0] pwdata,
  output logic [sdp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  sdp_char_if.sink                  char_i,
  sdp_res_if.source                 res_o
);
  import sdp_pkg::*;

  cfg_t cfg;

  sdp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .char_i (char_i),
    .res_o  (res_o)
  );

endmodule

// ===== tb/signed_decimal_parser_unit_tb.sv =====
// Self-checking testbench for signed_decimal_parser_unit: streams character
// beats, predicts each result beat and checks it. Depends on sdp_pkg, sdp_if.sv
// and the RTL of the block; it needs no other file.
`timescale 1ns / 1ps

module signed_decimal_parser_unit_tb;
  import sdp_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned PhaseBeats = 205;
  localparam logic [AddrW-1:0] ModeAddr = {RegNarrowMode, 2'b00};
  localparam logic [63:0] Long_Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Int_Max = 64'h0000_0000_7FFF_FFFF;

  typedef struct {
    logic        ok;
    logic [63:0] value;
    kind_e       kind;
  } parse_result_t;

  class token_scoreboard;
    logic          narrow;
    logic [63:0]   acc;
    logic          at_start;
    logic          negative;
    logic          bad_char;
    logic          overflowed;
    logic [1:0]    body_count;
    logic          first_is_zero;
    logic [7:0]    second_char;
    parse_result_t pending_results[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   token_ends;

    function new();
      narrow = 1'b0;
      mismatches = 0;
      checked = 0;
      token_ends = 0;
      clear_token();
    endfunction

    function void clear_token();
      acc = '0;
      at_start = 1'b1;
      negative = 1'b0;
      bad_char = 1'b0;
      overflowed = 1'b0;
      body_count = '0;
      first_is_zero = 1'b0;
      second_char = '0;
    endfunction

    function void set_mode(logic m);
      narrow = m;
    endfunction

    function void finish_token();
      parse_result_t r;
      logic [63:0]   max_mag;
      max_mag = narrow ? Int_Max : Long_Max;
      r.ok = 1'b0;
      r.value = '0;
      r.kind = KIND_ORDINARY;
      if (body_count == 2'd2 && first_is_zero &&
          !(second_char >= CharZero && second_char <= CharNine)) begin
        if (second_char == CharNull) begin
          if (!negative) begin
            r.ok = 1'b1;
            r.value = 64'd0 - max_mag - 64'd1;
            r.kind = KIND_NULL;
          end
        end else if (second_char == CharInf) begin
          r.ok = 1'b1;
          r.value = negative ? 64'd0 - max_mag : max_mag;
          r.kind = negative ? KIND_NEG_INF : KIND_POS_INF;
        end
      end else if (!bad_char && !overflowed) begin
        r.ok = 1'b1;
        r.value = negative ? 64'd0 - acc : acc;
      end
      pending_results.push_back(r);
      token_ends++;
    endfunction

    function void take_char(logic [7:0] c, logic last, logic empty);
      logic [63:0] max_mag;
      logic [63:0] digit;
      logic [7:0]  suffix;
      max_mag = narrow ? Int_Max : Long_Max;
      suffix = narrow ? CharSuffixInt : CharSuffixLong;
      if (empty) begin
        pending_results.push_back('{1'b0, 64'd0, KIND_ORDINARY});
        token_ends++;
        clear_token();
        return;
      end
      if (at_start && c == CharMinus) begin
        negative = 1'b1;
      end else if (!(last && c == suffix)) begin
        if (body_count == 2'd0) begin
          first_is_zero = (c == CharZero);
        end else if (body_count == 2'd1) begin
          second_char = c;
        end
        if (body_count != 2'd3) begin
          body_count++;
        end
        if (!(c >= CharZero && c <= CharNine)) begin
          bad_char = 1'b1;
        end else if (!overflowed) begin
          digit = 64'(c - CharZero);
          if (acc > (max_mag - digit) / 64'd10) begin
            overflowed = 1'b1;
          end else begin
            acc = acc * 64'd10 + digit;
          end
        end
      end
      at_start = 1'b0;
      if (last) begin
        finish_token();
        clear_token();
      end
    endfunction

    function void check_result(logic ok, logic [63:0] value, kind_e kind);
      parse_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with no token end waiting: valid_res %0b value %0h kind %s",
               ok, value, kind.name());
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (ok !== e.ok) begin
        $error("valid_res: expected %0b, got %0b", e.ok, ok);
        mismatches++;
      end
      if (value !== e.value) begin
        $error("value: expected %0h, got %0h", e.value, value);
        mismatches++;
      end
      if (kind !== e.kind) begin
        $error("kind: expected %s, got %s", e.kind.name(), kind.name());
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  sdp_char_if char_bus();
  sdp_res_if res_bus();

  signed_decimal_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .char_i (char_bus),
    .res_o  (res_bus)
  );

  token_scoreboard tokens = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_sent;
  int unsigned reg_writes;
  logic cur_mode;
  logic [7:0] tok_chars[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever @(posedge clk_i) begin
      if (res_bus.valid && res_bus.ready) begin
        tokens.check_result(res_bus.valid_res, res_bus.value, res_bus.kind);
      end
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((char_bus.valid && char_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no beat for %0d cycles.", IdleLimit);
    $display("simulation failed");
    $finish;
  end

  task automatic send_beat(logic [7:0] c, logic last, logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_bus.valid <= 1'b1;
    char_bus.ch <= c;
    char_bus.is_last <= last;
    char_bus.empty_token <= empty;
    do @(posedge clk_i); while (!char_bus.ready);
    tokens.take_char(c, last, empty);
    beats_sent++;
  endtask

  task automatic send_token(logic abandon);
    for (int i = 0; i < tok_chars.size(); i++) begin
      send_beat(tok_chars[i], !abandon && (i == tok_chars.size() - 1), 1'b0);
    end
    if (abandon) begin
      send_beat(8'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  task automatic send_text(string s, logic last);
    tok_chars.delete();
    for (int i = 0; i < s.len(); i++) begin
      tok_chars.push_back(s[i]);
    end
    if (last) begin
      send_token(1'b0);
    end else begin
      foreach (tok_chars[i]) send_beat(tok_chars[i], 1'b0, 1'b0);
    end
  endtask

  task automatic drain();
    char_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (tokens.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    logic [DataW-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ModeAddr;
    pwdata <= DataW'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tokens.set_mode(m);
    cur_mode = m;
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== DataW'(m)) begin
      $error("narrow_mode readback: expected %0h, got %0h", DataW'(m), readback);
      tokens.mismatches++;
    end
  endtask

  function automatic void append_decimal(logic [63:0] v);
    logic [7:0] rev[$];
    do begin
      rev.push_back(CharZero + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    while (rev.size() > 0) tok_chars.push_back(rev.pop_back());
  endfunction

  function automatic logic [7:0] rand_digit();
    return CharZero + 8'($urandom_range(9));
  endfunction

  // Builds one token in tok_chars; returns 1 when it is to be abandoned by an
  // empty-token beat instead of being ended normally.
  function automatic logic build_token();
    int unsigned pick;
    int unsigned ndig;
    logic [7:0]  suffix;
    logic [63:0] bound;
    pick = $urandom_range(99);
    suffix = cur_mode ? CharSuffixInt : CharSuffixLong;
    bound = cur_mode ? Int_Max : Long_Max;
    tok_chars.delete();
    if (pick < 40) begin
      if ($urandom_range(3) == 0) tok_chars.push_back(CharMinus);
      ndig = ($urandom_range(3) == 0) ? $urandom_range(1, cur_mode ? 11 : 20)
                                      : $urandom_range(1, 4);
      repeat (ndig) tok_chars.push_back(rand_digit());
      if ($urandom_range(1)) tok_chars.push_back(suffix);
    end else if (pick < 55) begin
      if ($urandom_range(1)) tok_chars.push_back(CharMinus);
      if ($urandom_range(4) == 0) tok_chars.push_back(CharZero);
      if ($urandom_range(1)) begin
        append_decimal(bound - 64'($urandom_range(6)));
      end else begin
        append_decimal(bound + 64'($urandom_range(1, 6)));
      end
      if ($urandom_range(5) == 0) tok_chars.push_back(rand_digit());
      if ($urandom_range(1)) tok_chars.push_back(suffix);
    end else if (pick < 70) begin
      if ($urandom_range(1)) tok_chars.push_back(CharMinus);
      tok_chars.push_back(($urandom_range(5) == 0) ? rand_digit() : CharZero);
      case ($urandom_range(5))
        0, 1: tok_chars.push_back(CharNull);
        2, 3: tok_chars.push_back(CharInf);
        4: tok_chars.push_back(cur_mode ? CharSuffixLong : CharSuffixInt);
        default: tok_chars.push_back(8'($urandom));
      endcase
      if ($urandom_range(4) == 0) tok_chars.push_back(rand_digit());
      if ($urandom_range(1)) tok_chars.push_back(suffix);
    end else if (pick < 78) begin
      case ($urandom_range(3))
        0: tok_chars.push_back(CharMinus);
        1: begin
          tok_chars.push_back(CharMinus);
          tok_chars.push_back(suffix);
        end
        2: tok_chars.push_back(suffix);
        default: begin
          tok_chars.push_back(suffix);
          tok_chars.push_back(rand_digit());
        end
      endcase
    end else if (pick < 84) begin
      return 1'b1;
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 5)) tok_chars.push_back(rand_digit());
      return 1'b1;
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0: tok_chars.push_back(CharMinus);
          1: tok_chars.push_back(suffix);
          2: tok_chars.push_back(rand_digit());
          default: tok_chars.push_back(8'($urandom));
        endcase
      end
    end
    return 1'b0;
  endfunction

  task automatic run_phase();
    int unsigned start;
    logic        abandon;
    start = beats_sent;
    while (beats_sent - start < PhaseBeats) begin
      abandon = build_token();
      send_token(abandon);
    end
    if ($urandom_range(1)) begin
      tok_chars.delete();
      repeat ($urandom_range(1, 3)) tok_chars.push_back(rand_digit());
      foreach (tok_chars[i]) send_beat(tok_chars[i], 1'b0, 1'b0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    char_bus.valid = 1'b0;
    char_bus.ch = '0;
    char_bus.is_last = 1'b0;
    char_bus.empty_token = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    beats_sent = 0;
    reg_writes = 0;
    cur_mode = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("-0Wj", 1'b1);
    send_text("0N", 1'b1);
    send_text("-0N", 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_text("-j", 1'b1);
    send_text("7", 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_text("1-", 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_text("0W", 1'b1);
    // A token that straddles a switch to 32-bit mode.
    send_text("12", 1'b0);
    drain();
    write_mode(1'b1);
    send_text("3i", 1'b1);
    send_text("0N", 1'b1);
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 35 : (p == 1) ? 70 : 0;
      recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 35 : 0;
      for (int k = 0; k < 3; k++) begin
        write_mode((k == 2) ? 1'($urandom) : 1'(k));
        run_phase();
        drain();
      end
    end

    $display("Sent %0d character beats ending %0d tokens; checked %0d result beats.",
             beats_sent, tokens.token_ends, tokens.checked);
    $display("Both widths ran under three idle profiles with %0d mode writes.", reg_writes);
    if (tokens.mismatches == 0 && tokens.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_if.sv
hw/rtl/sdp_cfg_regs.sv
hw/rtl/sdp_core.sv
hw/rtl/signed_decimal_parser_unit.sv
tb/signed_decimal_parser_unit_tb.sv
